// File: design/mlr_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint line rasterizer package
// Shared constants, register indexes and request codes for the rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

   // Default coordinate width; the top level takes it as its parameter default.
   localparam int CoordBitsDefault = 12;

   // Fixed field widths.
   localparam int PitchBits = 16;
   localparam int AddrBits  = 32;
   localparam int ColorBits = 8;
   localparam int CsrBits   = 32;

   // Depth of the queue between the stepping front and the address back end.
   localparam int QueueDepth = 4;

   // Configuration register indexes.
   localparam logic CsrLinePitch = 1'b0;
   localparam logic CsrFrameBase = 1'b1;

   // Register reset values.
   localparam logic [PitchBits-1:0] PitchReset = 16'd640;
   localparam logic [AddrBits-1:0]  BaseReset  = 32'd0;

   // Request kinds carried on the request tuser bit.
   localparam logic ReqStart   = 1'b0;
   localparam logic ReqAdvance = 1'b1;

endpackage

// File: design/mlr_front.sv
// ----------------------------------------------------------------------------
// Midpoint line rasterizer front end
// Accepts request words, sets up a line on start and steps the midpoint
// decision variable on advance, pushing one pixel word per result.
// ----------------------------------------------------------------------------
module mlr_front #(
   parameter int COORD_BITS = mlr_pkg::CoordBitsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_accept,
   input  logic                                  req_kind,
   input  logic [COORD_BITS-1:0]                 x_start,
   input  logic [COORD_BITS-1:0]                 y_start,
   input  logic [COORD_BITS-1:0]                 x_end,
   input  logic [COORD_BITS-1:0]                 y_end,
   input  logic [mlr_pkg::ColorBits-1:0]         pen_color,
   output logic                                  push_valid,
   // push_data fields, lowest bit first: x, y, colour, last
   output logic [2*COORD_BITS+mlr_pkg::ColorBits:0] push_data
);
   import mlr_pkg::*;

   localparam int DecBits = COORD_BITS + 2;

   logic                        busy_ff, busy_in;
   logic                        steep_ff, steep_in;
   logic [COORD_BITS-1:0]       major_pos_ff, major_pos_in;
   logic [COORD_BITS-1:0]       minor_pos_ff, minor_pos_in;
   logic [COORD_BITS-1:0]       major_end_ff, major_end_in;
   logic                        dir_down_ff, dir_down_in;
   logic signed [DecBits-1:0]   decision_ff, decision_in;
   logic signed [DecBits-1:0]   straight_ff, straight_in;
   logic signed [DecBits-1:0]   diagonal_ff, diagonal_in;
   logic [ColorBits-1:0]        color_ff, color_in;

   logic [COORD_BITS-1:0]       dx, dy, dmaj, dmin;
   logic [COORD_BITS-1:0]       a0, b0, a1, b1;
   logic                        steep_new;
   logic [DecBits-1:0]          dmin_x2, diff_ext;
   logic                        is_start, is_advance;
   logic                        last;
   logic [COORD_BITS-1:0]       px, py;

   // Line set-up: major axis, endpoint order and decision terms.
   always_comb begin
      dx        = (x_end > x_start) ? x_end - x_start : x_start - x_end;
      dy        = (y_end > y_start) ? y_end - y_start : y_start - y_end;
      steep_new = (dy > dx);
      if (steep_new) begin
         dmaj = dy;
         dmin = dx;
      end else begin
         dmaj = dx;
         dmin = dy;
      end
      a0 = steep_new ? y_start : x_start;
      b0 = steep_new ? x_start : y_start;
      a1 = steep_new ? y_end   : x_end;
      b1 = steep_new ? x_end   : y_end;
      if (a1 < a0) begin
         a0 = steep_new ? y_end   : x_end;
         b0 = steep_new ? x_end   : y_end;
         a1 = steep_new ? y_start : x_start;
         b1 = steep_new ? x_start : y_start;
      end
      dmin_x2  = {1'b0, dmin, 1'b0};
      diff_ext = {2'b00, dmin} - {2'b00, dmaj};
   end

   // Next state for start and advance, and the pixel word that follows it.
   always_comb begin
      is_start   = req_accept && (req_kind == ReqStart);
      is_advance = req_accept && (req_kind == ReqAdvance) && busy_ff;

      steep_in     = steep_ff;
      major_pos_in = major_pos_ff;
      minor_pos_in = minor_pos_ff;
      major_end_in = major_end_ff;
      dir_down_in  = dir_down_ff;
      decision_in  = decision_ff;
      straight_in  = straight_ff;
      diagonal_in  = diagonal_ff;
      color_in     = color_ff;

      if (is_start) begin
         steep_in     = steep_new;
         major_pos_in = a0;
         minor_pos_in = b0;
         major_end_in = a1;
         dir_down_in  = !(b1 > b0);
         decision_in  = $signed(dmin_x2 - {2'b00, dmaj});
         straight_in  = $signed(dmin_x2);
         diagonal_in  = $signed({diff_ext[DecBits-2:0], 1'b0});
         color_in     = pen_color;
      end else if (is_advance) begin
         major_pos_in = major_pos_ff + COORD_BITS'(1);
         if (decision_ff[DecBits-1]) begin
            decision_in = decision_ff + straight_ff;
         end else begin
            decision_in  = decision_ff + diagonal_ff;
            minor_pos_in = dir_down_ff ? minor_pos_ff - COORD_BITS'(1)
                                       : minor_pos_ff + COORD_BITS'(1);
         end
      end

      last       = (major_pos_in == major_end_in);
      px         = steep_in ? minor_pos_in : major_pos_in;
      py         = steep_in ? major_pos_in : minor_pos_in;
      push_valid = is_start || is_advance;
      push_data  = {last, color_in, py, px};
      busy_in    = push_valid ? !last : busy_ff;
   end

   // Line state registers, all cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         steep_ff     <= 1'b0;
         major_pos_ff <= '0;
         minor_pos_ff <= '0;
         major_end_ff <= '0;
         dir_down_ff  <= 1'b0;
         decision_ff  <= '0;
         straight_ff  <= '0;
         diagonal_ff  <= '0;
         color_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         steep_ff     <= steep_in;
         major_pos_ff <= major_pos_in;
         minor_pos_ff <= minor_pos_in;
         major_end_ff <= major_end_in;
         dir_down_ff  <= dir_down_in;
         decision_ff  <= decision_in;
         straight_ff  <= straight_in;
         diagonal_ff  <= diagonal_in;
         color_ff     <= color_in;
      end
   end

   // A final pixel always leaves the front end idle.
   a_last_clears_busy: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_data[2*COORD_BITS+ColorBits] |=> !busy_ff)
      else $error("front end still busy after the last pixel");

   // An advance word while idle produces nothing.
   a_idle_advance_silent: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_kind == ReqAdvance) && !busy_ff |-> !push_valid)
      else $error("advance while idle produced a pixel");

   // The walk position only moves when a word is accepted.
   a_position_holds: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(major_pos_ff) && $stable(busy_ff))
      else $error("line state changed without an accepted word");

endmodule

// File: design/mlr_queue.sv
// ----------------------------------------------------------------------------
// Midpoint line rasterizer queue
// Short first-in first-out queue of pixel words between front and back end.
// ----------------------------------------------------------------------------
module mlr_queue #(
   parameter int Width = 8,
   parameter int Depth = mlr_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             full,
   input  logic             pop_ready,
   output logic             pop_valid,
   output logic [Width-1:0] pop_data
);
   import mlr_pkg::*;

   localparam int PtrBits   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountBits = $clog2(Depth + 1);

   logic [Width-1:0]     store_ff [Depth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   // Occupancy and pointer update.
   always_comb begin
      full      = (count_ff == CountBits'(Depth));
      pop_valid = (count_ff != '0);
      pop_data  = store_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop_ready && pop_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(Depth - 1)) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(Depth - 1)) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CountBits'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountBits'(1);
      end
   end

   // Pointer and count registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountBits'(Depth))
      else $error("queue count above depth");

   a_push_only_grows: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + CountBits'(1))
      else $error("queue count did not grow on push");

   a_pop_only_shrinks: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> count_ff == $past(count_ff) - CountBits'(1))
      else $error("queue count did not shrink on pop");

endmodule

// File: design/mlr_back.sv
// ----------------------------------------------------------------------------
// Midpoint line rasterizer back end
// Two-stage pipeline that forms the byte address of each pixel word:
// row offset by multiplication, then base and column added.
// ----------------------------------------------------------------------------
module mlr_back #(
   parameter int COORD_BITS = mlr_pkg::CoordBitsDefault
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [mlr_pkg::PitchBits-1:0]            line_pitch,
   input  logic [mlr_pkg::AddrBits-1:0]             frame_base,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   // in_data fields, lowest bit first: x, y, colour, last
   input  logic [2*COORD_BITS+mlr_pkg::ColorBits:0] in_data,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic [COORD_BITS-1:0]                    pixel_x,
   output logic [COORD_BITS-1:0]                    pixel_y,
   output logic [mlr_pkg::AddrBits-1:0]             byte_address,
   output logic [mlr_pkg::ColorBits-1:0]            pixel_color,
   output logic                                     last_pixel
);
   import mlr_pkg::*;

   localparam int ProdBits = COORD_BITS + PitchBits;

   logic                  v1_ff, v1_in;
   logic [ProdBits-1:0]   prod_ff;
   logic [COORD_BITS-1:0] x1_ff, y1_ff;
   logic [ColorBits-1:0]  c1_ff;
   logic                  l1_ff;

   logic                  v2_ff, v2_in;
   logic [COORD_BITS-1:0] x2_ff, y2_ff;
   logic [AddrBits-1:0]   addr2_ff;
   logic [ColorBits-1:0]  c2_ff;
   logic                  l2_ff;

   logic                  adv1, adv2;
   logic [COORD_BITS-1:0] in_x, in_y;

   // Stage enables: a stage moves when the one after it is empty or moving.
   always_comb begin
      in_x     = in_data[COORD_BITS-1:0];
      in_y     = in_data[2*COORD_BITS-1:COORD_BITS];
      adv2     = !v2_ff || out_ready;
      adv1     = !v1_ff || adv2;
      in_ready = adv1;
      v1_in    = adv1 ? in_valid : v1_ff;
      v2_in    = adv2 ? v1_ff : v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // Stage one: row offset y times pitch.
   always_ff @(posedge clock) begin
      if (adv1) begin
         prod_ff <= ProdBits'(in_y) * ProdBits'(line_pitch);
         x1_ff   <= in_x;
         y1_ff   <= in_y;
         c1_ff   <= in_data[2*COORD_BITS+ColorBits-1:2*COORD_BITS];
         l1_ff   <= in_data[2*COORD_BITS+ColorBits];
      end
   end

   // Stage two: add base and column, modulo the address width.
   always_ff @(posedge clock) begin
      if (adv2) begin
         addr2_ff <= frame_base + AddrBits'(prod_ff) + AddrBits'(x1_ff);
         x2_ff    <= x1_ff;
         y2_ff    <= y1_ff;
         c2_ff    <= c1_ff;
         l2_ff    <= l1_ff;
      end
   end

   assign out_valid    = v2_ff;
   assign pixel_x      = x2_ff;
   assign pixel_y      = y2_ff;
   assign byte_address = addr2_ff;
   assign pixel_color  = c2_ff;
   assign last_pixel   = l2_ff;

endmodule

// File: design/midpoint_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// Midpoint line rasterizer
// Scan-converts lines for an 8-bit framebuffer, at most one pixel word per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : request words. tuser is the kind (start or advance); tdata holds
//            both endpoints and the colour. A start emits the first pixel,
//            each advance the next one; an advance while idle gives nothing,
//            and a start while a line is active abandons that line.
//   rsp_*  : pixel words with coordinates, byte address and colour; tlast
//            marks the final pixel of the line.
//   csr_*  : register writes (line pitch, frame base), made while idle.
// Path: the front end writes each pixel word into the queue, then the
//   multiplier stage and the adder stage register it. Throughput is one word
//   per cycle while rsp_tready stays high: the front end steps the decision
//   variable at most once per cycle and the back end is fully pipelined.
// A four-entry queue separates the two halves; req_tready falls only when it
//   is full, i.e. after the receiver has stalled.
// Reset clears the line state to idle, pitch to 640 and frame base to zero;
//   no result is pending afterwards.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_top #(
   parameter int COORD_BITS = mlr_pkg::CoordBitsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic                                 csr_addr,
   input  logic [mlr_pkg::CsrBits-1:0]          csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata fields, lowest bit first: x_start, y_start, x_end, y_end, pen_color
   input  logic [((4*COORD_BITS+mlr_pkg::ColorBits+7)/8)*8-1:0] req_tdata,
   // tuser fields: req_type
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata fields, lowest bit first: pixel_x, pixel_y, byte_address, pixel_color
   output logic [((2*COORD_BITS+mlr_pkg::AddrBits+mlr_pkg::ColorBits+7)/8)*8-1:0]
                                                rsp_tdata,
   output logic                                 rsp_tlast
);
   import mlr_pkg::*;

   localparam int ReqBits   = ((4*COORD_BITS + ColorBits + 7) / 8) * 8;
   localparam int RspFields = 2*COORD_BITS + AddrBits + ColorBits;
   localparam int RspBits   = ((RspFields + 7) / 8) * 8;
   localparam int WordBits  = 2*COORD_BITS + ColorBits + 1;

   logic [PitchBits-1:0]  pitch_ff;
   logic [AddrBits-1:0]   base_ff;

   logic                  req_accept;
   logic                  push_valid;
   logic [WordBits-1:0]   push_data;
   logic                  queue_full;
   logic                  q_valid, q_ready;
   logic [WordBits-1:0]   q_data;

   logic [COORD_BITS-1:0] pixel_x, pixel_y;
   logic [AddrBits-1:0]   byte_address;
   logic [ColorBits-1:0]  pixel_color;
   logic [ReqBits-1:0]    req_word;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= PitchReset;
         base_ff  <= BaseReset;
      end else if (csr_wen) begin
         case (csr_addr)
            CsrLinePitch: pitch_ff <= csr_wdata[PitchBits-1:0];
            CsrFrameBase: base_ff  <= csr_wdata[AddrBits-1:0];
            default:      ;
         endcase
      end
   end

   // Request side: accept whenever the queue has room.
   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;
   assign req_word   = req_tdata;

   mlr_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_kind   (req_tuser),
      .x_start    (req_word[COORD_BITS-1:0]),
      .y_start    (req_word[2*COORD_BITS-1:COORD_BITS]),
      .x_end      (req_word[3*COORD_BITS-1:2*COORD_BITS]),
      .y_end      (req_word[4*COORD_BITS-1:3*COORD_BITS]),
      .pen_color  (req_word[4*COORD_BITS+ColorBits-1:4*COORD_BITS]),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   mlr_queue #(
      .Width (WordBits),
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .full      (queue_full),
      .pop_ready (q_ready),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   mlr_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .line_pitch   (pitch_ff),
      .frame_base   (base_ff),
      .in_valid     (q_valid),
      .in_ready     (q_ready),
      .in_data      (q_data),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .pixel_x      (pixel_x),
      .pixel_y      (pixel_y),
      .byte_address (byte_address),
      .pixel_color  (pixel_color),
      .last_pixel   (rsp_tlast)
   );

   // Pack the result word, padded with zeros to whole bytes.
   assign rsp_tdata = RspBits'({pixel_color, byte_address, pixel_y, pixel_x});

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Midpoint line rasterizer testbench
// Drives start and advance request words with random idling and checks every
// pixel word against an in-bench line stepper. The register settings change
// between phases, and the receiver stalls for long stretches now and then.
// ----------------------------------------------------------------------------
module tb;
   import mlr_pkg::*;

   localparam int CoordBits = CoordBitsDefault;
   localparam int ReqBits   = ((4*CoordBits+ColorBits+7)/8)*8;
   localparam int RspBits   = ((2*CoordBits+AddrBits+ColorBits+7)/8)*8;
   localparam int CoordMax  = (1 << CoordBits) - 1;
   localparam int SettleCycles = 8;
   localparam int PadBits   = CsrBits - PitchBits;

   typedef struct packed {
      logic                 kind;
      logic [CoordBits-1:0] x0;
      logic [CoordBits-1:0] y0;
      logic [CoordBits-1:0] x1;
      logic [CoordBits-1:0] y1;
      logic [ColorBits-1:0] color;
   } req_word_type;

   typedef struct packed {
      logic [CoordBits-1:0] x;
      logic [CoordBits-1:0] y;
      logic [AddrBits-1:0]  addr;
      logic [ColorBits-1:0] color;
      logic                 last;
   } pixel_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               csr_wen    = 1'b0;
   logic               csr_addr   = 1'b0;
   logic [CsrBits-1:0] csr_wdata  = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [ReqBits-1:0] req_tdata  = '0;
   logic               req_tuser  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RspBits-1:0] rsp_tdata;
   logic               rsp_tlast;

   midpoint_line_rasterizer_top #(.COORD_BITS(CoordBits)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // Request words waiting to be offered, and pixel words still due.
   req_word_type pending_words[$];
   pixel_type    pixels_due[$];
   int           mismatch_count = 0;
   int           planned_pixels = 0;

   // Register copies and line state of the in-bench stepper.
   logic [PitchBits-1:0] pitch_cfg = PitchReset;
   logic [AddrBits-1:0]  base_cfg  = BaseReset;
   logic                 line_active = 1'b0;
   logic                 line_steep  = 1'b0;
   logic [CoordBits-1:0] major_at    = '0;
   logic [CoordBits-1:0] minor_at    = '0;
   logic [CoordBits-1:0] major_stop  = '0;
   logic                 minor_down  = 1'b0;
   int                   err_term    = 0;
   int                   step_square = 0;
   int                   step_diag   = 0;
   logic [ColorBits-1:0] line_color  = '0;

   // Queue the pixel at the current position and note whether the line ends.
   task automatic queue_pixel();
      pixel_type p;
      p.x     = line_steep ? minor_at : major_at;
      p.y     = line_steep ? major_at : minor_at;
      p.addr  = base_cfg + AddrBits'(p.y) * AddrBits'(pitch_cfg) + AddrBits'(p.x);
      p.color = line_color;
      p.last  = (major_at == major_stop);
      line_active = !p.last;
      pixels_due.push_back(p);
   endtask

   // Step the line for one accepted request word.
   task automatic rasterise_word(input req_word_type w);
      int dx, dy, dmaj, dmin;
      logic [CoordBits-1:0] a0, b0, a1, b1, t;
      if (w.kind == ReqStart) begin
         dx = (w.x1 > w.x0) ? int'(w.x1) - int'(w.x0) : int'(w.x0) - int'(w.x1);
         dy = (w.y1 > w.y0) ? int'(w.y1) - int'(w.y0) : int'(w.y0) - int'(w.y1);
         // Equal slopes fall to the x-major case.
         if (dy <= dx) begin
            line_steep = 1'b0;
            a0 = w.x0; b0 = w.y0; a1 = w.x1; b1 = w.y1;
            dmaj = dx; dmin = dy;
         end else begin
            line_steep = 1'b1;
            a0 = w.y0; b0 = w.x0; a1 = w.y1; b1 = w.x1;
            dmaj = dy; dmin = dx;
         end
         if (a1 < a0) begin
            t = a0; a0 = a1; a1 = t;
            t = b0; b0 = b1; b1 = t;
         end
         minor_down  = !(b1 > b0);
         major_at    = a0;
         minor_at    = b0;
         major_stop  = a1;
         err_term    = 2 * dmin - dmaj;
         step_square = 2 * dmin;
         step_diag   = 2 * (dmin - dmaj);
         line_color  = w.color;
         queue_pixel();
      end else if (line_active) begin
         major_at = major_at + CoordBits'(1);
         if (err_term < 0) begin
            err_term = err_term + step_square;
         end else begin
            err_term = err_term + step_diag;
            minor_at = minor_down ? minor_at - CoordBits'(1) : minor_at + CoordBits'(1);
         end
         queue_pixel();
      end
   endtask

   // Idle lengths: mostly none or short, now and then long.
   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch: %s got %0h expected %0h", what, got, want);
      mismatch_count++;
   endtask

   // Driver: offers queued request words and steps the predictor on acceptance.
   req_word_type offered_word;
   int           tx_gap  = 0;
   int           tx_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            rasterise_word(offered_word);
         end
         if (tx_gap > 0) begin
            tx_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            offered_word = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= offered_word.kind;
            req_tdata  <= ReqBits'({offered_word.color, offered_word.y1, offered_word.x1,
                                    offered_word.y0, offered_word.x0});
            if (tx_calm > 0) begin
               tx_calm--;
               tx_gap = 0;
            end else begin
               tx_gap = draw_gap();
               if ($urandom_range(0, 29) == 0) tx_calm = $urandom_range(20, 100);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: checks each pixel word and paces rsp_tready.
   pixel_type got_pixel;
   pixel_type want_pixel;
   int        rx_hold    = 0;
   int        rx_calm    = 0;
   int        pixel_seen = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_pixel.x     = rsp_tdata[CoordBits-1:0];
            got_pixel.y     = rsp_tdata[2*CoordBits-1:CoordBits];
            got_pixel.addr  = rsp_tdata[2*CoordBits+AddrBits-1:2*CoordBits];
            got_pixel.color = rsp_tdata[2*CoordBits+AddrBits+ColorBits-1:
                                        2*CoordBits+AddrBits];
            got_pixel.last  = rsp_tlast;
            if (pixels_due.size() == 0) begin
               report_mismatch("pixel word with none due, address", got_pixel.addr, 0);
            end else begin
               want_pixel = pixels_due.pop_front();
               if (got_pixel.x != want_pixel.x)
                  report_mismatch("pixel_x", 32'(got_pixel.x), 32'(want_pixel.x));
               if (got_pixel.y != want_pixel.y)
                  report_mismatch("pixel_y", 32'(got_pixel.y), 32'(want_pixel.y));
               if (got_pixel.addr != want_pixel.addr)
                  report_mismatch("byte_address", got_pixel.addr, want_pixel.addr);
               if (got_pixel.color != want_pixel.color)
                  report_mismatch("pixel_color", 32'(got_pixel.color),
                                  32'(want_pixel.color));
               if (got_pixel.last != want_pixel.last)
                  report_mismatch("last_pixel", 32'(got_pixel.last),
                                  32'(want_pixel.last));
            end
            pixel_seen++;
            // Long hold-offs so that the internal queue fills and the input stalls.
            if (pixel_seen == 150 || pixel_seen == 900) rx_hold = 90;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rx_calm > 0) begin
               rx_calm--;
            end else begin
               rx_hold = draw_gap();
               if ($urandom_range(0, 29) == 0) rx_calm = $urandom_range(20, 100);
            end
         end
      end
   end

   // Stimulus helpers.
   function automatic req_word_type random_word(input logic kind);
      req_word_type w;
      w.kind  = kind;
      w.x0    = CoordBits'($urandom);
      w.y0    = CoordBits'($urandom);
      w.x1    = CoordBits'($urandom);
      w.y1    = CoordBits'($urandom);
      w.color = ColorBits'($urandom);
      return w;
   endfunction

   task automatic push_start(input int x0, input int y0, input int x1, input int y1,
                             input int color);
      req_word_type w;
      w.kind  = ReqStart;
      w.x0    = CoordBits'(x0);
      w.y0    = CoordBits'(y0);
      w.x1    = CoordBits'(x1);
      w.y1    = CoordBits'(y1);
      w.color = ColorBits'(color);
      pending_words.push_back(w);
   endtask

   task automatic push_advances(input int count);
      repeat (count) pending_words.push_back(random_word(ReqAdvance));
   endtask

   function automatic int near_coord(input int c, input int span);
      int v;
      v = c + $urandom_range(0, 2 * span) - span;
      if (v < 0) v = 0;
      if (v > CoordMax) v = CoordMax;
      return v;
   endfunction

   // One random line: mostly short and run to its end, sometimes cut short by
   // the next start, sometimes followed by advances that fall on an idle block.
   task automatic add_random_line();
      req_word_type w;
      int span, dx, dy, major, steps, roll;
      w = random_word(ReqStart);
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
         span = ($urandom_range(0, 9) == 0) ? 64 : 12;
         w.x1 = CoordBits'(near_coord(int'(w.x0), span));
         w.y1 = CoordBits'(near_coord(int'(w.y0), span));
      end
      pending_words.push_back(w);
      dx = (w.x1 > w.x0) ? int'(w.x1) - int'(w.x0) : int'(w.x0) - int'(w.x1);
      dy = (w.y1 > w.y0) ? int'(w.y1) - int'(w.y0) : int'(w.y0) - int'(w.y1);
      major = (dx > dy) ? dx : dy;
      roll = $urandom_range(0, 99);
      if (major > 80) steps = $urandom_range(0, 40);
      else if (roll < 75) steps = major;
      else if (roll < 88) steps = major + $urandom_range(1, 3);
      else steps = $urandom_range(0, major);
      push_advances(steps);
      planned_pixels += 1 + ((steps < major) ? steps : major);
   endtask

   task automatic add_random_phase(input int pixel_target);
      planned_pixels = 0;
      while (planned_pixels < pixel_target) begin
         if ($urandom_range(0, 19) == 0) push_advances(1);
         else add_random_line();
      end
   endtask

   // Wait until all words are through and nothing more is due; sampled away
   // from the rising edge so the driver's updates are settled.
   task automatic wait_idle();
      while (pending_words.size() != 0 || req_tvalid || pixels_due.size() != 0)
         @(negedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_registers(input logic [PitchBits-1:0] pitch,
                                  input logic [AddrBits-1:0] base);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= CsrLinePitch;
      csr_wdata <= {PadBits'($urandom), pitch};
      pitch_cfg  = pitch;
      @(posedge clock);
      csr_addr  <= CsrFrameBase;
      csr_wdata <= base;
      base_cfg   = base;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   // Main sequence: directed words and a random phase under the reset settings,
   // then random phases under a range of pitch and base settings.
   logic [PitchBits-1:0] phase_pitch[4];
   logic [AddrBits-1:0]  phase_base[4];

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Single point, advance while idle, extreme corners with a line
      // abandoned by the next start, horizontal, reversed vertical, equal
      // slopes, steep, and a single point at the far corner.
      push_start(0, 0, 0, 0, 8'h00);
      push_advances(1);
      push_start(CoordMax, 0, 0, CoordMax, 8'hFF);
      push_advances(2);
      push_start(10, 20, 14, 20, 8'h5A);
      push_advances(5);
      push_start(7, 100, 7, 97, 8'hA5);
      push_advances(3);
      push_start(3, 3, 0, 0, 8'h0F);
      push_advances(3);
      push_start(5, 5, 6, 9, 8'hF0);
      push_advances(4);
      push_start(CoordMax, CoordMax, CoordMax, CoordMax, 8'h3C);
      add_random_phase(200);
      wait_idle();

      // Zero pitch first, then the extremes, then a random setting.
      phase_pitch[0] = '0;            phase_base[0] = 32'h8000_0001;
      phase_pitch[1] = 16'd1;         phase_base[1] = 32'hFFFF_FFFF;
      phase_pitch[2] = 16'hFFFF;      phase_base[2] = 32'hFFFF_F000;
      phase_pitch[3] = PitchBits'($urandom_range(1, 16'hFFFF));
      phase_base[3]  = $urandom;
      for (int i = 0; i < 4; i++) begin
         write_registers(phase_pitch[i], phase_base[i]);
         add_random_phase((i < 2) ? 200 : 300);
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("[midpoint_line_rasterizer_top] OK");
      end else begin
         $display("[midpoint_line_rasterizer_top] ERROR");
      end
      $finish;
   end

   // Overall time limit.
   initial begin
      #20_000_000;
      $display("[midpoint_line_rasterizer_top] ERROR");
      $finish;
   end

endmodule
